// File: src/canonical_kmer_counter_core_assert.svh
// assertion macros shared by the counter modules
`ifndef CANONICAL_KMER_COUNTER_CORE_ASSERT_SVH
`define CANONICAL_KMER_COUNTER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CKC_ASSERT_IMM(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ckc assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CKC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ckc assertion failed");

`endif

// File: src/ckc_pkg.sv
package ckc_pkg;

  localparam int CFG_W          = 4;
  localparam int BASE_W         = 2;
  localparam int KEY_W          = 16;
  localparam int CNT_W          = 32;
  localparam int MAX_K_DEF      = 8;
  localparam int COUNT_BITS_DEF = 32;
  localparam int BITS_PER_BASE  = 2;
  localparam int OQ_DEPTH       = 3;

  localparam logic [CFG_W-1:0]  KMER_LEN_RST = 4'd8;
  localparam logic [BASE_W-1:0] COMP_MASK    = 2'b01;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } ckc_res_t;

  typedef struct packed {
    logic clearing;
    logic s1_emit;
  } ckc_stat_t;

endpackage

// File: src/ckc_if.sv
interface ckc_in_if;
  import ckc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base_code;
  logic              seq_start;

  modport source (output valid, output base_code, output seq_start, input ready);
  modport sink (input valid, input base_code, input seq_start, output ready);
endinterface

interface ckc_out_if;
  import ckc_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] kmer_key;
  logic [CNT_W-1:0] kmer_count;

  modport source (output valid, output kmer_key, output kmer_count, input ready);
  modport sink (input valid, input kmer_key, input kmer_count, output ready);
endinterface

// File: src/canonical_kmer_counter_core.sv
// canonical k-mer counter
// in_ch carries one base per transfer (base_code, seq_start); seq_start
// restarts the k-base window with that base. once k bases of the current
// sequence are in, each base yields one out_ch transfer with the canonical
// k-mer and its new saturating count; earlier bases yield nothing.
// cfg_we/cfg_wdata write kmer_len (k); the user must write it only while
// the block is idle, which the block does not enforce. throughput is one
// base per cycle while in_ch.ready is high, set by the count memory read-
// modify-write: read at the transfer edge, write in the cycle after, with
// the last write forwarded to the next item; results pass s1, then the queue.
// reset clears the window and sets k to 8, then a clearing pass zeroes the
// count memory, all 4^MAX_K entries (65536 by default), with in_ch.ready low.
// when out_ch stalls, results collect in a three-entry output queue and
// in_ch.ready drops only once the queue and the pipeline would fill.
module canonical_kmer_counter_core #(
  parameter int MAX_K      = ckc_pkg::MAX_K_DEF,
  parameter int COUNT_BITS = ckc_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ckc_pkg::CFG_W-1:0] cfg_wdata,
  ckc_in_if.sink                    in_ch,
  ckc_out_if.source                 out_ch
);
  import ckc_pkg::*;

  localparam int W  = 2 * MAX_K;
  localparam int CW = $clog2(OQ_DEPTH + 1);

  logic [CFG_W-1:0] kmer_len_r;
  logic             accept;
  logic             req_emit;
  logic [W-1:0]     req_key;
  logic             push;
  ckc_res_t         res;
  ckc_stat_t        stat;
  logic [CW-1:0]    q_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= KMER_LEN_RST;
    end else if (cfg_we) begin
      kmer_len_r <= cfg_wdata;
    end
  end

  // room for the item in flight plus this one in the output queue
  assign in_ch.ready = !stat.clearing &&
                       ((CW+1)'(q_cnt) + (CW+1)'(stat.s1_emit) <= (CW+1)'(OQ_DEPTH - 1));
  assign accept      = in_ch.valid && in_ch.ready;

  ckc_window #(
    .MAX_K (MAX_K)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .base_code (in_ch.base_code),
    .seq_start (in_ch.seq_start),
    .kmer_len  (kmer_len_r),
    .emit      (req_emit),
    .key       (req_key)
  );

  ckc_count #(
    .MAX_K      (MAX_K),
    .COUNT_BITS (COUNT_BITS)
  ) u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_emit (req_emit),
    .req_key  (req_key),
    .push     (push),
    .res      (res),
    .stat     (stat)
  );

  ckc_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .q_cnt     (q_cnt),
    .out_ch    (out_ch)
  );

endmodule

// File: src/ckc_window.sv
module ckc_window #(
  parameter int MAX_K = ckc_pkg::MAX_K_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [ckc_pkg::BASE_W-1:0]  base_code,
  input  logic                        seq_start,
  input  logic [ckc_pkg::CFG_W-1:0]   kmer_len,
  output logic                        emit,
  output logic [2*MAX_K-1:0]          key
);
  import ckc_pkg::*;

  localparam int W  = 2 * MAX_K;
  localparam int KW = $clog2(MAX_K + 1);

  logic [W-1:0]  fwd_r, fwd_nxt, rev_r, rev_nxt;
  logic [W-1:0]  fwd_base, rev_base, mask, ins;
  logic [KW-1:0] seen_r, seen_nxt, seen_base, k_eff;
  logic [CFG_W:0] len_x;
  logic [KW:0]   sh;

  // clamp length into 1..MAX_K
  always_comb begin
    len_x = {1'b0, kmer_len};
    if (len_x == '0) begin
      k_eff = KW'(1);
    end else if (len_x > (CFG_W+1)'(MAX_K)) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(len_x);
    end
  end

  always_comb begin
    for (int i = 0; i < W; i++) begin
      mask[i] = ((i >> 1) < int'(k_eff));
    end
  end

  // rolling forward and reverse-complement words
  always_comb begin
    fwd_base  = seq_start ? '0 : fwd_r;
    rev_base  = seq_start ? '0 : rev_r;
    seen_base = seq_start ? '0 : seen_r;
    sh        = {k_eff, 1'b0} - (KW+1)'(BITS_PER_BASE);
    ins       = W'(base_code ^ COMP_MASK) << sh;
    fwd_nxt   = ((fwd_base << BITS_PER_BASE) | W'(base_code)) & mask;
    rev_nxt   = ((rev_base >> BITS_PER_BASE) | ins) & mask;
    seen_nxt  = (seen_base < KW'(MAX_K)) ? seen_base + KW'(1) : seen_base;
    emit      = accept && (seen_nxt >= k_eff);
    key       = (fwd_nxt < rev_nxt) ? fwd_nxt : rev_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= '0;
      rev_r  <= '0;
      seen_r <= '0;
    end else if (accept) begin
      fwd_r  <= fwd_nxt;
      rev_r  <= rev_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// File: src/ckc_count.sv
`include "canonical_kmer_counter_core_assert.svh"

module ckc_count #(
  parameter int MAX_K      = ckc_pkg::MAX_K_DEF,
  parameter int COUNT_BITS = ckc_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_emit,
  input  logic [2*MAX_K-1:0] req_key,
  output logic               push,
  output ckc_pkg::ckc_res_t  res,
  output ckc_pkg::ckc_stat_t stat
);
  import ckc_pkg::*;

  localparam int W = 2 * MAX_K;
  localparam longint unsigned DEPTH = 64'd1 << W;

  logic [COUNT_BITS-1:0] mem [DEPTH];

  logic                  clr_busy_r;
  logic [W-1:0]          clr_addr_r;
  logic                  s1_valid_r;
  logic [W-1:0]          s1_key_r;
  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  wb_valid_r;
  logic [W-1:0]          wb_key_r;
  logic [COUNT_BITS-1:0] wb_cnt_r;

  logic                  fwd_hit;
  logic [COUNT_BITS-1:0] cnt_base, cnt_new;
  logic                  wr_en;
  logic [W-1:0]          wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  // read data misses the write made at the same edge, so forward it
  always_comb begin
    fwd_hit  = wb_valid_r && (wb_key_r == s1_key_r);
    cnt_base = fwd_hit ? wb_cnt_r : rd_data_r;
    cnt_new  = (&cnt_base) ? cnt_base : cnt_base + COUNT_BITS'(1);
    wr_en    = clr_busy_r || s1_valid_r;
    wr_addr  = clr_busy_r ? clr_addr_r : s1_key_r;
    wr_data  = clr_busy_r ? '0 : cnt_new;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[req_key];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      s1_valid_r <= 1'b0;
      wb_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + W'(1);
        if (&clr_addr_r) begin
          clr_busy_r <= 1'b0;
        end
      end
      s1_valid_r <= req_emit;
      wb_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_key_r <= req_key;
    wb_key_r <= s1_key_r;
    wb_cnt_r <= cnt_new;
  end

  assign push          = s1_valid_r;
  assign res.key       = KEY_W'(s1_key_r);
  assign res.cnt       = CNT_W'(cnt_new);
  assign stat.clearing = clr_busy_r;
  assign stat.s1_emit  = s1_valid_r;

  `CKC_ASSERT_IMM(a_no_item_in_clear, clr_busy_r, !req_emit)
  `CKC_ASSERT_NXT(a_fwd_tracks_write, s1_valid_r, wb_valid_r && wb_key_r == $past(s1_key_r))
  `CKC_ASSERT_IMM(a_count_nonzero, s1_valid_r, cnt_new != '0)

endmodule

// File: src/ckc_ofifo.sv
`include "canonical_kmer_counter_core_assert.svh"

module ckc_ofifo (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  input  ckc_pkg::ckc_res_t                      push_data,
  output logic [$clog2(ckc_pkg::OQ_DEPTH+1)-1:0] q_cnt,
  ckc_out_if.source                              out_ch
);
  import ckc_pkg::*;

  localparam int PW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  ckc_res_t      entries_r [OQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] q_cnt_r;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(OQ_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign pop               = out_ch.valid && out_ch.ready;
  assign out_ch.valid      = (q_cnt_r != '0);
  assign out_ch.kmer_key   = entries_r[rd_ptr_r].key;
  assign out_ch.kmer_count = entries_r[rd_ptr_r].cnt;
  assign q_cnt             = q_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        q_cnt_r <= q_cnt_r + CW'(1);
      end else if (pop && !push) begin
        q_cnt_r <= q_cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  `CKC_ASSERT_IMM(a_oq_no_overflow, push && !pop, q_cnt_r < CW'(OQ_DEPTH))
  `CKC_ASSERT_IMM(a_oq_empty_ptrs, q_cnt_r == '0, wr_ptr_r == rd_ptr_r)

endmodule
